@@ design/jsbm_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jsbm_pkg
// Types and constants shared by the joystick shaping block and its parts.
// -----------------------------------------------------------------------------
package jsbm_pkg;

  localparam int CFG_DATA_W = 9;
  localparam int XY_DZ_W    = 9;
  localparam int ROT_DZ_W   = 7;
  localparam int MAG_W      = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_XY_DEADZONE  = 1'b0;
  localparam logic REG_ROT_DEADZONE = 1'b1;

  localparam logic [XY_DZ_W-1:0]  XY_DZ_RESET  = 9'd32;
  localparam logic [ROT_DZ_W-1:0] ROT_DZ_RESET = 7'd8;

  localparam logic [3:0] BTN_NONE       = 4'd0;
  localparam logic [3:0] BTN_MENU_FIRST = 4'd1;
  localparam logic [3:0] BTN_MENU_LAST  = 4'd5;
  localparam logic [3:0] BTN_TOG_BASE   = 4'd6;
  localparam logic [3:0] BTN_TOG_FIRST  = 4'd7;
  localparam logic [3:0] BTN_TOG_LAST   = 4'd12;
  localparam logic [3:0] BTN_SAVE_FIRST = 4'd8;
  localparam logic [3:0] BTN_SAVE_LAST  = 4'd11;
  localparam logic [3:0] BTN_SQUARE     = 4'd9;

  localparam logic [2:0] MENU_DEFAULT = 3'd0;
  localparam logic [2:0] TOG_NONE     = 3'd0;

  typedef struct packed {
    logic [9:0] x_raw;
    logic [9:0] y_raw;
    logic [7:0] twist_raw;
    logic [7:0] slider_raw;
    logic [3:0] button;
  } joy_in_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] rotation_out;
    logic [14:0]        speed_out;
    logic [3:0]         button_echo;
    logic [2:0]         menu_sel;
    logic [2:0]         toggle_code;
    logic               save_request;
    logic               square_enabled;
  } joy_out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [9:0] x_mag;
    logic       x_neg;
    logic [9:0] y_mag;
    logic       y_neg;
    logic [7:0] rot_mag;
    logic       rot_neg;
    logic [7:0] spd_mag;
    logic       square;
    logic [3:0] button_echo;
    logic [2:0] menu_sel;
    logic [2:0] toggle_code;
    logic       save_request;
    logic       square_enabled;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } bk_state_t;

endpackage

@@ design/jsbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jsbm_front
// Accepts raw reports, applies deadzones, tracks button edges, menu and the
// square flag, and pushes a classified request into the queue.
// -----------------------------------------------------------------------------
module jsbm_front import jsbm_pkg::*; #(
  parameter bit SQUARE_AT_START = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  joy_in_t               in_data,
  input  logic                  q_full,
  output logic                  push,
  output job_t                  push_job
);

  logic [XY_DZ_W-1:0]  xy_deadzone;
  logic [ROT_DZ_W-1:0] rotation_deadzone;
  logic [3:0]          prev_button;
  logic [2:0]          menu_reg;
  logic                square_flag;

  logic [9:0] x_dist, y_dist;
  logic [7:0] t_dist;
  logic       x_live, y_live, t_live;
  logic       btn_edge;
  logic [2:0] menu_next;
  logic [2:0] code;
  logic       save;
  logic       square_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_deadzone       <= XY_DZ_RESET;
      rotation_deadzone <= ROT_DZ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_XY_DEADZONE:  xy_deadzone <= cfg_data[XY_DZ_W-1:0];
        REG_ROT_DEADZONE: rotation_deadzone <= cfg_data[ROT_DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off requests while in reset
  assign in_stall = q_full || rst;
  assign push     = in_valid && !in_stall;

  always_comb begin
    x_dist = in_data.x_raw[9] ? {1'b0, in_data.x_raw[8:0]} : 10'd512 - in_data.x_raw;
    y_dist = in_data.y_raw[9] ? {1'b0, in_data.y_raw[8:0]} : 10'd512 - in_data.y_raw;
    t_dist = (in_data.twist_raw >= 8'd127) ? in_data.twist_raw - 8'd127
                                           : 8'd127 - in_data.twist_raw;
    x_live = x_dist > {1'b0, xy_deadzone};
    y_live = y_dist > {1'b0, xy_deadzone};
    t_live = t_dist > {1'b0, rotation_deadzone};

    btn_edge = (in_data.button != BTN_NONE) && (prev_button == BTN_NONE);
    menu_next = menu_reg;
    code = TOG_NONE;
    save = 1'b0;
    square_next = square_flag;
    if (btn_edge) begin
      if (in_data.button >= BTN_MENU_FIRST && in_data.button <= BTN_MENU_LAST) begin
        menu_next = in_data.button[2:0] - 3'd1;
      end
      if (in_data.button >= BTN_TOG_FIRST && in_data.button <= BTN_TOG_LAST) begin
        code = 3'(in_data.button - BTN_TOG_BASE);
        save = (in_data.button >= BTN_SAVE_FIRST) && (in_data.button <= BTN_SAVE_LAST);
      end
      if (in_data.button == BTN_SQUARE) begin
        square_next = ~square_flag;
      end
    end

    push_job.x_mag   = x_live ? (in_data.x_raw[9] ? {in_data.x_raw[8:0], 1'b1}
                                                  : {~in_data.x_raw[8:0], 1'b1}) : 10'd0;
    push_job.x_neg   = ~in_data.x_raw[9];
    push_job.y_mag   = y_live ? (in_data.y_raw[9] ? {in_data.y_raw[8:0], 1'b1}
                                                  : {~in_data.y_raw[8:0], 1'b1}) : 10'd0;
    push_job.y_neg   = ~in_data.y_raw[9];
    push_job.rot_mag = t_live ? (in_data.twist_raw[7] ? {in_data.twist_raw[6:0], 1'b1}
                                                      : {~in_data.twist_raw[6:0], 1'b1})
                              : 8'd0;
    push_job.rot_neg = in_data.twist_raw[7];
    push_job.spd_mag = in_data.slider_raw;
    push_job.square  = square_flag;
    push_job.button_echo    = in_data.button;
    push_job.menu_sel       = menu_next;
    push_job.toggle_code    = code;
    push_job.save_request   = save;
    push_job.square_enabled = square_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_button <= BTN_NONE;
      menu_reg    <= MENU_DEFAULT;
      square_flag <= SQUARE_AT_START;
    end else if (push) begin
      prev_button <= in_data.button;
      menu_reg    <= menu_next;
      square_flag <= square_next;
    end
  end

endmodule
`default_nettype wire

@@ design/jsbm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jsbm_queue
// Short FIFO of classified requests between front and back.
// -----------------------------------------------------------------------------
module jsbm_queue import jsbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/jsbm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jsbm_back
// Scales, optionally squares and snaps one request at a time through a shared 16x16
// multiplier, then loads the result register.
// -----------------------------------------------------------------------------
module jsbm_back import jsbm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_not_empty,
  input  job_t     head_job,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output joy_out_t out_data
);

  localparam logic [2:0] OP_SQ_X  = 3'd0;
  localparam logic [2:0] OP_SQ_Y  = 3'd1;
  localparam logic [2:0] OP_SQ_R  = 3'd2;
  localparam logic [2:0] OP_SQ_S  = 3'd3;
  localparam logic [2:0] OP_AX2   = 3'd4;
  localparam logic [2:0] OP_SUM2  = 3'd5;
  localparam logic [2:0] OP_DIFF2 = 3'd6;
  localparam logic [2:0] OP_END   = 3'd7;

  bk_state_t state, state_next;
  logic [2:0] step;
  logic       prod_valid;
  logic [31:0] prod;

  logic [MAG_W-1:0] x_m, y_m, r_m, s_m;
  logic             x_neg, y_neg, r_neg;
  logic [28:0] sqa, sqd;
  logic [30:0] sqs;
  logic [3:0]  button_echo;
  logic [2:0]  menu_sel, toggle_code;
  logic        save_request, square_enabled;

  logic [15:0] mul_a, mul_b;
  logic [28:0] rnd;
  logic        out_free, out_load;

  logic             cond_a, cond_b;
  logic [MAG_W-1:0] mx, xo_m, yo_m;

  // round(m * 16384 / 1023) for odd m, via the 2^10-1 divide identity
  function automatic logic [MAG_W-1:0] scale_xy(input logic [9:0] m);
    logic [13:0] t;
    logic [14:0] y;
    logic [14:0] s;
    t = {m, 4'b0};
    y = {1'b0, t} + 15'd511;
    s = y + {10'd0, y[14:10]} + 15'd1;
    return {1'b0, t} + {10'd0, s[14:10]};
  endfunction

  // round(m * 16384 / 255), via the 2^8-1 divide identity
  function automatic logic [MAG_W-1:0] scale_byte(input logic [7:0] m);
    logic [13:0] t;
    logic [14:0] y;
    logic [14:0] s;
    t = {m, 6'b0};
    y = {1'b0, t} + 15'd127;
    s = y + {8'd0, y[14:8]} + 15'd1;
    return {1'b0, t} + {8'd0, s[14:8]};
  endfunction

  function automatic logic signed [15:0] to_signed(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_not_empty) state_next = BK_RUN;
      BK_RUN:  if (step == OP_END) state_next = BK_FIN;
      BK_FIN:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == BK_IDLE) && q_not_empty;
    out_load = (state == BK_FIN) && out_free;
  end

  always_comb begin
    case (step)
      OP_SQ_X:  begin mul_a = {1'b0, x_m}; mul_b = {1'b0, x_m}; end
      OP_SQ_Y:  begin mul_a = {1'b0, y_m}; mul_b = {1'b0, y_m}; end
      OP_SQ_R:  begin mul_a = {1'b0, r_m}; mul_b = {1'b0, r_m}; end
      OP_SQ_S:  begin mul_a = {1'b0, s_m}; mul_b = {1'b0, s_m}; end
      OP_AX2:   begin mul_a = {1'b0, x_m}; mul_b = {1'b0, x_m}; end
      OP_SUM2:  begin
        mul_a = {1'b0, x_m} + {1'b0, y_m};
        mul_b = mul_a;
      end
      OP_DIFF2: begin
        mul_a = {1'b0, y_m} - {1'b0, x_m};
        mul_b = mul_a;
      end
      default:  begin mul_a = 16'd0; mul_b = 16'd0; end
    endcase
    rnd = prod[28:0] + 29'd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= OP_SQ_X;
      prod_valid <= 1'b0;
    end else if (pop) begin
      step       <= head_job.square ? OP_SQ_X : OP_AX2;
      prod_valid <= 1'b0;
    end else if (state == BK_RUN) begin
      step       <= step + 3'd1;
      prod_valid <= (step != OP_END);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_m            <= scale_xy(head_job.x_mag);
      y_m            <= scale_xy(head_job.y_mag);
      r_m            <= scale_byte(head_job.rot_mag);
      s_m            <= scale_byte(head_job.spd_mag);
      x_neg          <= head_job.x_neg;
      y_neg          <= head_job.y_neg;
      r_neg          <= head_job.rot_neg;
      button_echo    <= head_job.button_echo;
      menu_sel       <= head_job.menu_sel;
      toggle_code    <= head_job.toggle_code;
      save_request   <= head_job.save_request;
      square_enabled <= head_job.square_enabled;
    end else if (state == BK_RUN) begin
      prod <= 32'(mul_a * mul_b);
      if (prod_valid) begin
        case (step - 3'd1)
          OP_SQ_X:  x_m <= rnd[28:14];
          OP_SQ_Y:  y_m <= rnd[28:14];
          OP_SQ_R:  r_m <= rnd[28:14];
          OP_SQ_S:  s_m <= rnd[28:14];
          OP_AX2:   sqa <= prod[28:0];
          OP_SUM2:  sqs <= prod[30:0];
          OP_DIFF2: sqd <= prod[28:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cond_a = ({1'b0, sqs} < {2'b0, sqa, 1'b0}) || (x_m == '0 && y_m == '0);
    cond_b = (y_m > x_m) && ({1'b0, sqd} > {sqa, 1'b0});
    mx     = (x_m > y_m) ? x_m : y_m;
    if (cond_a) begin
      xo_m = x_m;
      yo_m = '0;
    end else if (cond_b) begin
      xo_m = '0;
      yo_m = y_m;
    end else begin
      xo_m = mx;
      yo_m = mx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.x_out          <= to_signed(x_neg, xo_m);
      out_data.y_out          <= to_signed(y_neg, yo_m);
      out_data.rotation_out   <= to_signed(r_neg, r_m);
      out_data.speed_out      <= s_m;
      out_data.button_echo    <= button_echo;
      out_data.menu_sel       <= menu_sel;
      out_data.toggle_code    <= toggle_code;
      out_data.save_request   <= save_request;
      out_data.square_enabled <= square_enabled;
    end
  end

endmodule
`default_nettype wire

@@ design/joystick_shaping_with_button_menu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// joystick_shaping_with_button_menu
// Joystick report shaping: deadzones, Q2.14 scaling, optional squaring,
// eight-way snapping, and button-driven menu and toggle codes.
// -----------------------------------------------------------------------------
// One result per accepted report. The front takes a report and queues up to
// two of them while the back handles one report at a time on a single shared
// 16x16 multiplier: with square shaping on, load, four squarings and three
// snap products overlapped, then finish; with it off the squarings are
// skipped. Button 9 flips square shaping from the next report on. Deadzone
// registers: index 0 is the X/Y deadzone, index 1 the rotation deadzone;
// write them only while the block is idle.
module joystick_shaping_with_button_menu import jsbm_pkg::*; #(
  parameter bit SQUARE_AT_START = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  joy_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output joy_out_t              out_data,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_full, q_not_empty, push, pop;
  job_t push_job, head_job;

  jsbm_front #(
    .SQUARE_AT_START(SQUARE_AT_START)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  jsbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  jsbm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
